FILE: rtl/core/lfsa_pkg.sv
package lfsa_pkg;

	localparam int HUE_W        = 9;
	localparam int SAT_W        = 8;
	localparam int VAL_W        = 8;
	localparam int LED_IDX_W    = 5;
	localparam int LEN_W        = 6;
	localparam int PAT_W        = 3;
	localparam int CFG_IDX_W    = 2;
	localparam int CFG_DATA_W   = 9;
	localparam int MAX_LEDS_DEF = 32;

	typedef struct packed {
		logic [HUE_W-1:0] hue;
		logic [SAT_W-1:0] sat;
		logic [VAL_W-1:0] val;
	} color_t;

	typedef struct packed {
		logic [VAL_W-1:0] cur;
		logic [VAL_W-1:0] goal;
		logic             fill;
	} ramp_req_t;

	typedef struct packed {
		logic [VAL_W-1:0] nxt;
		logic             same;
	} ramp_rsp_t;

endpackage

FILE: rtl/core/led_strip_fade_shift_animator.sv
// LED strip fade and shift animator. Holds hue, saturation and value for up to
// MAX_LEDS LEDs in a store with a read and a write port and advances one of six
// patterns per tick. A start word or an idle tick is taken without leaving idle.
// An active tick over n LEDs makes a read-modify-write pass through the store
// and the shared ramp unit, reading then updating each LED, then one result word
// per LED read back from the store. Input is stalled for the whole tick.
module led_strip_fade_shift_animator #(
	parameter int MAX_LEDS = lfsa_pkg::MAX_LEDS_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_we,
	input  logic [lfsa_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [lfsa_pkg::CFG_DATA_W-1:0] cfg_data,
	input  logic                            in_valid,
	output logic                            in_stall,
	input  logic                            command,
	input  logic [lfsa_pkg::PAT_W-1:0]      pattern,
	input  logic                            turn_on,
	output logic                            out_valid,
	input  logic                            out_stall,
	output logic [lfsa_pkg::LED_IDX_W-1:0]  led_index,
	output logic [lfsa_pkg::HUE_W-1:0]      hue_out,
	output logic [lfsa_pkg::SAT_W-1:0]      saturation_out,
	output logic [lfsa_pkg::VAL_W-1:0]      value_out,
	output logic                            last_led,
	output logic                            finished
);
	import lfsa_pkg::*;

	localparam int IW     = $clog2(MAX_LEDS);
	localparam int NW     = $clog2(MAX_LEDS + 1);
	localparam int CW     = (NW > LEN_W) ? NW : LEN_W;
	localparam int MODE_W = PAT_W + 1;
	localparam logic [MODE_W-1:0] MODE_IDLE = '0;
	localparam logic [MODE_W-1:0] MODE_LAST = MODE_W'(12);
	localparam logic [LEN_W-1:0]  LEN_RESET = LEN_W'(8);
	localparam logic CMD_TICK  = 1'b0;
	localparam logic CMD_START = 1'b1;

	typedef enum logic [4:0] {
		ST_IDLE = 5'b00001,
		ST_RD   = 5'b00010,
		ST_UPD  = 5'b00100,
		ST_ORD  = 5'b01000,
		ST_OUT  = 5'b10000
	} state_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_TARGET_HUE = 2'd0,
		REG_TARGET_SAT = 2'd1,
		REG_TARGET_VAL = 2'd2,
		REG_STRIP_LEN  = 2'd3
	} cfg_reg_t;

	typedef enum logic [PAT_W-1:0] {
		PAT_SWITCH     = 3'd0,
		PAT_FILL       = 3'd1,
		PAT_FILL_RIGHT = 3'd2,
		PAT_FILL_LEFT  = 3'd3,
		PAT_RUN_RIGHT  = 3'd4,
		PAT_RUN_LEFT   = 3'd5
	} pattern_t;

	state_t            state_q;
	logic [HUE_W-1:0]  tgt_hue_q;
	logic [SAT_W-1:0]  tgt_sat_q;
	logic [VAL_W-1:0]  tgt_val_q;
	logic [LEN_W-1:0]  len_q;
	logic [MODE_W-1:0] mode_q;
	pattern_t          pat_q;
	logic              on_q;
	logic [NW-1:0]     n_q;
	logic [NW-1:0]     k_q;
	color_t            prev_q;
	logic              same_q;

	logic              in_acc;
	logic              out_acc;
	logic              tick_go;
	logic              k_last;
	logic              down;
	logic [NW-1:0]     upd_idx;
	logic [MODE_W-1:0] m1;
	logic [CW-1:0]     len_c;
	logic [NW-1:0]     n_start;
	color_t            tgt_c;
	color_t            start_c;
	color_t            old_c;
	color_t            new_c;
	logic              led_same;
	ramp_req_t         rq;
	ramp_rsp_t         rs;
	logic              rd_en;
	logic [IW-1:0]     rd_addr;
	logic              wr_en;

	assign in_stall  = state_q != ST_IDLE;
	assign in_acc    = in_valid && !in_stall;
	assign out_valid = state_q == ST_OUT;
	assign out_acc   = out_valid && !out_stall;
	assign k_last    = k_q == (n_q - NW'(1));
	assign down      = (pat_q == PAT_FILL_LEFT) || (pat_q == PAT_RUN_RIGHT);
	assign upd_idx   = down ? (n_q - NW'(1) - k_q) : k_q;
	assign m1        = mode_q - MODE_W'(1);
	assign tick_go   = in_acc && (command == CMD_TICK) && (mode_q != MODE_IDLE)
	                   && (mode_q <= MODE_LAST);

	always_comb begin
		len_c = CW'(len_q);
		if (len_c < CW'(2)) begin
			n_start = NW'(2);
		end else if (len_c > CW'(MAX_LEDS)) begin
			n_start = NW'(MAX_LEDS);
		end else begin
			n_start = NW'(len_c);
		end
	end

	always_comb begin
		tgt_c.hue   = tgt_hue_q;
		tgt_c.sat   = tgt_sat_q;
		tgt_c.val   = on_q ? tgt_val_q : '0;
		start_c.hue = tgt_hue_q;
		start_c.sat = tgt_sat_q;
		start_c.val = m1[0] ? tgt_val_q : '0;
	end

	lfsa_store #(.DEPTH(MAX_LEDS)) u_store (
		.clk     (clk),
		.arst_n  (arst_n),
		.rd_en   (rd_en),
		.rd_addr (rd_addr),
		.rd_data (old_c),
		.wr_en   (wr_en),
		.wr_addr (IW'(upd_idx)),
		.wr_data (new_c)
	);

	lfsa_ramp u_ramp (
		.req (rq),
		.rsp (rs)
	);

	always_comb begin
		rq.cur  = old_c.val;
		rq.fill = pat_q == PAT_FILL;
		rq.goal = (pat_q == PAT_FILL) ? tgt_c.val : prev_q.val;
		case (pat_q) inside
			PAT_SWITCH: begin
				new_c    = tgt_c;
				led_same = 1'b1;
			end
			PAT_FILL: begin
				new_c.hue = tgt_c.hue;
				new_c.sat = tgt_c.sat;
				new_c.val = rs.nxt;
				led_same  = rs.same;
			end
			PAT_FILL_RIGHT, PAT_FILL_LEFT: begin
				new_c.hue = prev_q.hue;
				new_c.sat = prev_q.sat;
				new_c.val = rs.nxt;
				led_same  = rs.same;
			end
			default: begin
				new_c    = prev_q;
				led_same = old_c == prev_q;
			end
		endcase
	end

	always_comb begin
		wr_en = state_q == ST_UPD;
		unique case (state_q)
			ST_RD: begin
				rd_en   = 1'b1;
				rd_addr = IW'(upd_idx);
			end
			ST_ORD: begin
				rd_en   = 1'b1;
				rd_addr = '0;
			end
			ST_OUT: begin
				rd_en   = out_acc && !k_last;
				rd_addr = IW'(k_q + NW'(1));
			end
			default: begin
				rd_en   = 1'b0;
				rd_addr = '0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tgt_hue_q <= '0;
			tgt_sat_q <= '0;
			tgt_val_q <= '0;
			len_q     <= LEN_RESET;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_TARGET_HUE: tgt_hue_q <= cfg_data[HUE_W-1:0];
				REG_TARGET_SAT: tgt_sat_q <= cfg_data[SAT_W-1:0];
				REG_TARGET_VAL: tgt_val_q <= cfg_data[VAL_W-1:0];
				REG_STRIP_LEN:  len_q     <= cfg_data[LEN_W-1:0];
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			mode_q  <= MODE_IDLE;
			pat_q   <= PAT_SWITCH;
			on_q    <= 1'b0;
			n_q     <= '0;
			k_q     <= '0;
			prev_q  <= '0;
			same_q  <= 1'b0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (in_acc && (command == CMD_START)) begin
						if (pattern <= PAT_RUN_LEFT) begin
							mode_q <= {pattern, turn_on} + MODE_W'(1);
						end
					end else if (tick_go) begin
						pat_q   <= pattern_t'(m1[MODE_W-1:1]);
						on_q    <= m1[0];
						n_q     <= n_start;
						k_q     <= '0;
						prev_q  <= start_c;
						same_q  <= 1'b1;
						state_q <= ST_RD;
					end
				end
				ST_RD: begin
					state_q <= ST_UPD;
				end
				ST_UPD: begin
					prev_q <= old_c;
					same_q <= same_q && led_same;
					if (k_last) begin
						k_q     <= '0;
						state_q <= ST_ORD;
						if (same_q && led_same) begin
							mode_q <= MODE_IDLE;
						end
					end else begin
						k_q     <= k_q + NW'(1);
						state_q <= ST_RD;
					end
				end
				ST_ORD: begin
					state_q <= ST_OUT;
				end
				ST_OUT: begin
					if (out_acc) begin
						if (k_last) begin
							state_q <= ST_IDLE;
						end else begin
							k_q <= k_q + NW'(1);
						end
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign led_index      = LED_IDX_W'(k_q);
	assign hue_out        = old_c.hue;
	assign saturation_out = old_c.sat;
	assign value_out      = old_c.val;
	assign last_led       = k_last;
	assign finished       = same_q;

	a_busy_while_out: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> in_stall)
		else $error("input taken while result words pending");

	a_idle_after_last: assert property (@(posedge clk) disable iff (!arst_n)
		(out_acc && last_led) |=> !in_stall)
		else $error("block not idle after last word of tick");

	a_index_steps: assert property (@(posedge clk) disable iff (!arst_n)
		(out_acc && !last_led) |=> (out_valid && led_index == $past(led_index) + 1'b1))
		else $error("led index did not advance by one");

	a_finished_stable: assert property (@(posedge clk) disable iff (!arst_n)
		(out_acc && !last_led) |=> finished == $past(finished))
		else $error("finished flag changed within a tick");

	a_finished_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && finished) |-> mode_q == MODE_IDLE)
		else $error("finished tick left a mode running");

endmodule

FILE: rtl/core/lfsa_ramp.sv
module lfsa_ramp (
	input  lfsa_pkg::ramp_req_t req,
	output lfsa_pkg::ramp_rsp_t rsp
);
	import lfsa_pkg::*;

	localparam int FILL_DIV    = 10;
	localparam int SHIFT_DIV   = 4;
	localparam int RECIP_SHIFT = 11;
	// exact quotient for every 8-bit diff
	localparam int FILL_RECIP  = (1 << RECIP_SHIFT) / FILL_DIV + 1;
	localparam int PROD_W      = VAL_W + RECIP_SHIFT;

	logic             up;
	logic [VAL_W-1:0] diff;
	logic [VAL_W-1:0] quo;
	logic [VAL_W-1:0] step;
	logic [PROD_W-1:0] prod;

	always_comb begin
		up   = req.cur < req.goal;
		diff = up ? (req.goal - req.cur) : (req.cur - req.goal);
		prod = PROD_W'(diff) * PROD_W'(FILL_RECIP);
		if (req.fill) begin
			quo = VAL_W'(prod >> RECIP_SHIFT);
		end else begin
			quo = VAL_W'(diff / SHIFT_DIV);
		end
		step     = quo + VAL_W'(1);
		rsp.same = req.cur == req.goal;
		if (rsp.same) begin
			rsp.nxt = req.cur;
		end else if (up) begin
			rsp.nxt = req.cur + step;
		end else begin
			rsp.nxt = req.cur - step;
		end
	end

endmodule

FILE: rtl/core/lfsa_store.sv
module lfsa_store #(
	parameter int DEPTH = lfsa_pkg::MAX_LEDS_DEF,
	localparam int AW = $clog2(DEPTH)
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             rd_en,
	input  logic [AW-1:0]    rd_addr,
	output lfsa_pkg::color_t rd_data,
	input  logic             wr_en,
	input  logic [AW-1:0]    wr_addr,
	input  lfsa_pkg::color_t wr_data
);
	import lfsa_pkg::*;

	color_t            mem [DEPTH];
	logic [DEPTH-1:0]  vld_q;
	color_t            rd_data_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	// never-written entries read as black
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (wr_en) begin
			vld_q[wr_addr] <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data_q <= vld_q[rd_addr] ? mem[rd_addr] : '0;
		end
	end

	assign rd_data = rd_data_q;

endmodule

FILE: tb/testbench.sv
module testbench;
	timeunit 1ns;
	timeprecision 1ps;

	import lfsa_pkg::*;

	localparam int NUM_LEDS = MAX_LEDS_DEF;

	localparam logic CMD_TICK  = 1'b0;
	localparam logic CMD_START = 1'b1;

	localparam logic [PAT_W-1:0] PAT_SWITCH     = 3'd0;
	localparam logic [PAT_W-1:0] PAT_FILL       = 3'd1;
	localparam logic [PAT_W-1:0] PAT_FILL_RIGHT = 3'd2;
	localparam logic [PAT_W-1:0] PAT_FILL_LEFT  = 3'd3;
	localparam logic [PAT_W-1:0] PAT_RUN_RIGHT  = 3'd4;
	localparam logic [PAT_W-1:0] PAT_RUN_LEFT   = 3'd5;
	localparam logic [PAT_W-1:0] PAT_SPARE6     = 3'd6;
	localparam logic [PAT_W-1:0] PAT_SPARE7     = 3'd7;

	localparam logic [CFG_IDX_W-1:0] REG_HUE = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_SAT = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_VAL = 2'd2;
	localparam logic [CFG_IDX_W-1:0] REG_LEN = 2'd3;

	localparam int FILL_STEP_DIV  = 10;
	localparam int SHIFT_STEP_DIV = 4;
	localparam int QUIET_LIMIT    = 4000;
	localparam int HOLD_CYCLES    = 300;
	localparam int DRAIN_CYCLES   = 8;
	localparam int TAIL_CYCLES    = 120;
	localparam int MAX_TICKS      = 40;

	typedef struct packed {
		logic [LED_IDX_W-1:0] idx;
		logic [HUE_W-1:0]     hue;
		logic [SAT_W-1:0]     sat;
		logic [VAL_W-1:0]     val;
		logic                 tail;
		logic                 done;
	} led_word_t;

	class strip_frame_checker;
		color_t            leds[NUM_LEDS];
		bit                active;
		logic [PAT_W-1:0]  act_pattern;
		bit                act_on;
		logic [HUE_W-1:0]  goal_hue;
		logic [SAT_W-1:0]  goal_sat;
		logic [VAL_W-1:0]  goal_val;
		logic [LEN_W-1:0]  length_reg;
		led_word_t         pending[$];
		int                faults;
		int                checked;
		int                unchanged;

		function new();
			foreach (leds[i])
				leds[i] = '0;
			active = 0;
			act_pattern = PAT_SWITCH;
			act_on = 0;
			goal_hue = '0;
			goal_sat = '0;
			goal_val = '0;
			length_reg = LEN_W'(8);
			faults = 0;
			checked = 0;
			unchanged = 0;
		endfunction

		function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
			case (idx)
				REG_HUE: goal_hue = data[HUE_W-1:0];
				REG_SAT: goal_sat = data[SAT_W-1:0];
				REG_VAL: goal_val = data[VAL_W-1:0];
				default: length_reg = data[LEN_W-1:0];
			endcase
		endfunction

		function logic [VAL_W-1:0] ramp(int cur, int goal, int div);
			if (cur < goal)
				return cur + (goal - cur) / div + 1;
			if (cur > goal)
				return cur - (cur - goal) / div - 1;
			unchanged++;
			return cur;
		endfunction

		function void take(int j, color_t src, color_t old);
			if (old == src)
				unchanged++;
			leds[j] = src;
		endfunction

		function void apply_word(logic cmd, logic [PAT_W-1:0] pat, logic on_form);
			color_t prev[NUM_LEDS];
			color_t goal;
			int n;
			led_word_t w;
			if (cmd == CMD_START) begin
				if (pat <= PAT_RUN_LEFT) begin
					active = 1;
					act_pattern = pat;
					act_on = on_form;
				end
				return;
			end
			if (!active)
				return;
			n = (length_reg < 2) ? 2 : ((length_reg > NUM_LEDS) ? NUM_LEDS : int'(length_reg));
			goal.hue = goal_hue;
			goal.sat = goal_sat;
			goal.val = act_on ? goal_val : '0;
			prev = leds;
			unchanged = 0;
			// neighbors always come from the old frame
			case (act_pattern)
				PAT_SWITCH: begin
					for (int j = 0; j < n; j++)
						leds[j] = goal;
					unchanged = n;
				end
				PAT_FILL: begin
					for (int j = 0; j < n; j++) begin
						leds[j].hue = goal.hue;
						leds[j].sat = goal.sat;
						leds[j].val = ramp(prev[j].val, goal.val, FILL_STEP_DIV);
					end
				end
				PAT_FILL_RIGHT: begin
					for (int j = 1; j < n; j++) begin
						leds[j].hue = prev[j-1].hue;
						leds[j].sat = prev[j-1].sat;
						leds[j].val = ramp(prev[j].val, prev[j-1].val, SHIFT_STEP_DIV);
					end
					leds[0].hue = goal.hue;
					leds[0].sat = goal.sat;
					leds[0].val = ramp(prev[0].val, goal.val, SHIFT_STEP_DIV);
				end
				PAT_FILL_LEFT: begin
					for (int j = 0; j < n - 1; j++) begin
						leds[j].hue = prev[j+1].hue;
						leds[j].sat = prev[j+1].sat;
						leds[j].val = ramp(prev[j].val, prev[j+1].val, SHIFT_STEP_DIV);
					end
					leds[n-1].hue = goal.hue;
					leds[n-1].sat = goal.sat;
					leds[n-1].val = ramp(prev[n-1].val, goal.val, SHIFT_STEP_DIV);
				end
				PAT_RUN_RIGHT: begin
					for (int j = 0; j < n - 1; j++)
						take(j, prev[j+1], prev[j]);
					take(n - 1, goal, prev[n-1]);
				end
				default: begin
					for (int j = n - 1; j > 0; j--)
						take(j, prev[j-1], prev[j]);
					take(0, goal, prev[0]);
				end
			endcase
			if (unchanged == n)
				active = 0;
			for (int j = 0; j < n; j++) begin
				w.idx = LED_IDX_W'(j);
				w.hue = leds[j].hue;
				w.sat = leds[j].sat;
				w.val = leds[j].val;
				w.tail = (j == n - 1);
				w.done = !active;
				pending.push_back(w);
			end
		endfunction

		function void check_led(led_word_t got);
			led_word_t want;
			checked++;
			if (pending.size() == 0) begin
				faults++;
				if (faults <= 10)
					$display("LED word %0d not expected: idx %0d hue %0d sat %0d val %0d",
						checked, got.idx, got.hue, got.sat, got.val);
				return;
			end
			want = pending.pop_front();
			if (got.idx !== want.idx || got.hue !== want.hue || got.sat !== want.sat ||
				got.val !== want.val || got.tail !== want.tail || got.done !== want.done) begin
				faults++;
				if (faults <= 10) begin
					$display("LED word %0d wrong: expected idx %0d hue %0d sat %0d val %0d last %0b fin %0b",
						checked, want.idx, want.hue, want.sat, want.val, want.tail, want.done);
					$display("  got idx %0d hue %0d sat %0d val %0d last %0b fin %0b",
						got.idx, got.hue, got.sat, got.val, got.tail, got.done);
				end
			end
		endfunction
	endclass

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  cfg_we = 1'b0;
	logic [CFG_IDX_W-1:0]  cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_data = '0;
	logic                  in_valid = 1'b0;
	logic                  in_stall;
	logic                  command = 1'b0;
	logic [PAT_W-1:0]      pattern = '0;
	logic                  turn_on = 1'b0;
	logic                  out_valid;
	logic                  out_stall = 1'b0;
	logic [LED_IDX_W-1:0]  led_index;
	logic [HUE_W-1:0]      hue_out;
	logic [SAT_W-1:0]      saturation_out;
	logic [VAL_W-1:0]      value_out;
	logic                  last_led;
	logic                  finished;

	strip_frame_checker board;
	bit steady = 0;
	bit hold_off = 0;
	int words_in = 0;
	int settings = 0;

	led_strip_fade_shift_animator i_dut (.*);

	initial begin
		forever #6 clk = ~clk;
	end

	task automatic send_word(input logic cmd, input logic [PAT_W-1:0] pat, input logic on_form);
		int unsigned gap;
		gap = steady ? 0 : $urandom_range(0, 3);
		@(negedge clk);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		in_valid <= 1'b1;
		command <= cmd;
		pattern <= pat;
		turn_on <= on_form;
		do @(posedge clk); while (in_stall);
		board.apply_word(cmd, pat, on_form);
		words_in++;
	endtask

	task automatic start_and_tick(input logic [PAT_W-1:0] pat, input logic on_form);
		send_word(CMD_START, pat, on_form);
		send_word(CMD_TICK, PAT_W'($urandom), 1'($urandom));
	endtask

	task automatic settle();
		@(negedge clk);
		in_valid <= 1'b0;
		while (board.pending.size() != 0)
			@(negedge clk);
		repeat (DRAIN_CYCLES) @(negedge clk);
	endtask

	task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		board.write_reg(idx, data);
		@(negedge clk);
	endtask

	// spare upper data bits are random to show they are dropped
	task automatic configure(input int hue, input int sat, input int val, input int len);
		settle();
		cfg_write(REG_HUE, CFG_DATA_W'(hue));
		cfg_write(REG_SAT, {1'($urandom), SAT_W'(sat)});
		cfg_write(REG_VAL, {1'($urandom), VAL_W'(val)});
		cfg_write(REG_LEN, {3'($urandom), LEN_W'(len)});
		cfg_we <= 1'b0;
		settings++;
	endtask

	task automatic random_phase(input int budget);
		int counted;
		int ticks;
		int cap;
		logic cmd;
		logic on_form;
		logic [PAT_W-1:0] pat;
		counted = 0;
		while (counted < budget) begin
			if ($urandom_range(0, 9) == 0) begin
				cmd = 1'($urandom);
				pat = PAT_W'($urandom);
				on_form = 1'($urandom);
				if ((cmd == CMD_START && pat <= PAT_RUN_LEFT) || (cmd == CMD_TICK && board.active))
					counted++;
				send_word(cmd, pat, on_form);
			end else begin
				send_word(CMD_START, PAT_W'($urandom_range(PAT_SWITCH, PAT_RUN_LEFT)),
					1'($urandom));
				counted++;
				cap = ($urandom_range(0, 4) == 0) ? $urandom_range(1, 3) : MAX_TICKS;
				ticks = 0;
				while (board.active && ticks < cap) begin
					send_word(CMD_TICK, PAT_W'($urandom), 1'($urandom));
					ticks++;
					counted++;
				end
			end
		end
	endtask

	initial begin
		int hue;
		int len;
		board = new();
		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		configure(359, 255, 255, 2);
		send_word(CMD_TICK, PAT_SWITCH, 1'b1);
		send_word(CMD_START, PAT_SPARE6, 1'b1);
		send_word(CMD_START, PAT_SPARE7, 1'b0);
		send_word(CMD_TICK, PAT_SPARE7, 1'b0);
		start_and_tick(PAT_SWITCH, 1'b1);
		send_word(CMD_TICK, PAT_RUN_LEFT, 1'b1);
		start_and_tick(PAT_FILL, 1'b0);
		start_and_tick(PAT_FILL_RIGHT, 1'b1);
		start_and_tick(PAT_FILL_LEFT, 1'b0);
		start_and_tick(PAT_RUN_RIGHT, 1'b1);
		start_and_tick(PAT_RUN_LEFT, 1'b0);
		start_and_tick(PAT_FILL, 1'b1);
		start_and_tick(PAT_SWITCH, 1'b0);
		// oversize length saturates to the full strip, hue above range passes through
		configure(511, 0, 128, 63);
		start_and_tick(PAT_RUN_LEFT, 1'b1);
		send_word(CMD_TICK, PAT_FILL, 1'b0);
		configure(0, 255, 1, 1);
		start_and_tick(PAT_RUN_RIGHT, 1'b0);

		for (int p = 0; p < 6; p++) begin
			hue = ($urandom_range(0, 7) == 0) ? $urandom_range(360, 511) : $urandom_range(0, 359);
			case (p)
				2: len = NUM_LEDS;
				4: len = $urandom_range(33, 63);
				5: len = $urandom_range(0, 1);
				default: len = $urandom_range(2, 8);
			endcase
			configure(hue, $urandom_range(0, 255), $urandom_range(0, 255), len);
			steady = (p == 3);
			hold_off = (p == 2);
			random_phase((p == 2) ? 10 : 17);
		end
		steady = 0;

		settle();
		repeat (TAIL_CYCLES) @(negedge clk);
		$display("Covered %0d input words over %0d register settings, %0d LED words checked:",
			words_in, settings, board.checked);
		$display("  all patterns on and off, spare codes, idle ticks, length clamp, long hold.");
		if (board.faults == 0) begin
			$display("DONE: 0 errors");
		end else begin
			$display("DONE: errors detected");
		end
		$finish;
	end

	initial begin : result_sink
		int unsigned pause;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (out_valid && !out_stall) begin
				if (hold_off) begin
					pause = HOLD_CYCLES;
					hold_off = 0;
				end else begin
					pause = steady ? 0 : $urandom_range(0, 3);
				end
				if (pause > 0) begin
					@(negedge clk);
					out_stall <= 1'b1;
					repeat (pause) @(negedge clk);
					out_stall <= 1'b0;
				end
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall)
			board.check_led(led_word_t'({led_index, hue_out, saturation_out, value_out,
				last_led, finished}));
	end

	initial begin : watchdog
		int unsigned quiet;
		quiet = 0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if ((in_valid && !in_stall) || (out_valid && !out_stall))
				quiet = 0;
			else
				quiet++;
			if (quiet >= QUIET_LIMIT) begin
				$display("Timeout: no word moved for %0d cycles, %0d LED words pending",
					quiet, board.pending.size());
				$display("DONE: errors detected");
				$finish;
			end
		end
	end

endmodule
